// File: hdl/b64d_pkg.sv
// Shared types, character constants and the alphabet lookup for the base64 decoder.
package b64d_pkg;

   // Character codes that the decoder treats specially.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // Offsets that move each alphabet range onto its six-bit value.
   localparam logic [7:0] LOWER_OFFSET = 8'd71;  // 'a' - 26
   localparam logic [7:0] DIGIT_OFFSET = 8'd4;   // 52 - '0'
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   localparam logic [1:0] GROUP_LAST_POS = 2'd3;
   localparam logic [1:0] PAD_MAX        = 2'd3;
   localparam logic [1:0] BYTES_FULL     = 2'd3;

   // One finished group as it travels from the front end to the byte emitter.
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  count;
      logic        eom;
   } group_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - LOWER_OFFSET;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c + DIGIT_OFFSET;
      end else if (c == CHAR_PLUS) begin
         d = {2'b00, SEXTET_PLUS};
      end else if (c == CHAR_SLASH) begin
         d = {2'b00, SEXTET_SLASH};
      end
      return d[5:0];
   endfunction

endpackage

// File: hdl/b64d_req_if.sv
// Character input channel: valid/ready handshake with one character per transfer.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_message;

   modport source (output valid, output char_code, output end_of_message, input ready);
   modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

// File: hdl/b64d_rsp_if.sv
// Byte output channel: valid/ready handshake with one decoded byte per transfer.
interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/b64d_front.sv
// Front end: takes characters, decodes sextets and assembles four-character groups.
module b64d_front (
   input  logic                clock,
   input  logic                reset,
   b64d_req_if.sink            req_ch,
   input  logic                queue_full,
   output logic                push,
   output b64d_pkg::group_type push_group
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pad_ff, pad_in;
   logic        accept;
   logic [5:0]  sextet;
   logic [1:0]  pad_next;
   logic [1:0]  nbytes;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign sextet       = b64d_pkg::sextet_of(req_ch.char_code);

   always_comb begin
      pad_next = pad_ff;
      if (req_ch.char_code == b64d_pkg::CHAR_PAD && pad_ff != b64d_pkg::PAD_MAX) begin
         pad_next = pad_ff + 2'd1;
      end
      // Each pad character drops one byte from the tail of the group.
      nbytes = b64d_pkg::BYTES_FULL - pad_next;

      push_group.word  = {acc_ff, sextet};
      push_group.count = nbytes;
      push_group.eom   = req_ch.end_of_message;
      push             = accept && pos_ff == b64d_pkg::GROUP_LAST_POS && nbytes != 2'd0;

      pos_in = pos_ff;
      acc_in = acc_ff;
      pad_in = pad_ff;
      if (accept) begin
         if (pos_ff == b64d_pkg::GROUP_LAST_POS || req_ch.end_of_message) begin
            // Group complete, or a partial group cut off by end of message.
            pos_in = 2'd0;
            acc_in = 18'd0;
            pad_in = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
            acc_in = {acc_ff[11:0], sextet};
            pad_in = pad_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         acc_ff <= 18'd0;
         pad_ff <= 2'd0;
      end else begin
         pos_ff <= pos_in;
         acc_ff <= acc_in;
         pad_ff <= pad_in;
      end
   end

`ifndef SYNTHESIS
   a_push_has_bytes: assert property (@(posedge clock) disable iff (reset)
      push |-> push_group.count != 2'd0)
      else $error("group pushed with no bytes");
`endif

endmodule

// File: hdl/b64d_queue.sv
// Small register queue of decoded groups between the front end and the byte emitter.
module b64d_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::group_type push_group,
   input  logic                pop,
   output b64d_pkg::group_type pop_group,
   output logic                full,
   output logic                empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   b64d_pkg::group_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == FULL_CNT;
   assign empty     = count_ff == '0;
   assign pop_group = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");
`endif

endmodule

// File: hdl/b64d_back.sv
// Byte emitter: splits queued groups into bytes behind a registered output stage.
module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  b64d_pkg::group_type pop_group,
   input  logic                empty,
   output logic                pop,
   b64d_rsp_if.source          rsp_ch
);

   logic        cur_valid_ff, cur_valid_in;
   logic [23:0] cur_word_ff, cur_word_in;
   logic [1:0]  cur_left_ff, cur_left_in;
   logic        cur_eom_ff, cur_eom_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_load;
   logic        emit;
   logic        final_byte;

   assign out_load   = !rsp_valid_ff || rsp_ch.ready;
   assign emit       = cur_valid_ff && out_load;
   assign final_byte = cur_left_ff == 2'd1;
   assign pop        = !empty && (!cur_valid_ff || (emit && final_byte));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_word_in  = cur_word_ff;
      cur_left_in  = cur_left_ff;
      cur_eom_in   = cur_eom_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_word_in  = pop_group.word;
         cur_left_in  = pop_group.count;
         cur_eom_in   = pop_group.eom;
      end else if (emit) begin
         cur_valid_in = !final_byte;
         cur_word_in  = {cur_word_ff[15:0], 8'd0};
         cur_left_in  = cur_left_ff - 2'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = emit;
         rsp_data_in  = cur_word_ff[23:16];
         rsp_last_in  = cur_eom_ff && final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_word_ff <= cur_word_in;
      cur_left_ff <= cur_left_in;
      cur_eom_ff  <= cur_eom_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.data_byte = rsp_data_ff;
   assign rsp_ch.last_byte = rsp_last_ff;

`ifndef SYNTHESIS
   a_group_drains: assert property (@(posedge clock) disable iff (reset)
      (emit && final_byte && !pop) |=> !cur_valid_ff)
      else $error("group still held after its final byte");
`endif

endmodule

// File: hdl/base64_stream_decoder_core.sv
// Top level of the streaming base64 decoder: front end, group queue and byte emitter.
// Throughput: one character accepted per cycle while the queue is not full, and one
// byte delivered per cycle while the sink is ready. A group goes from its fourth
// character through the queue and the group register to the output register.
// Reset is synchronous and active high; it clears the partial group, empties the queue
// and drops any byte not yet delivered. There is no clearing pass.
module base64_stream_decoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   b64d_req_if.sink  req_ch,
   b64d_rsp_if.source rsp_ch
);

   // Groups with at least one byte cross from the front end to the emitter through
   // the queue. The front end stalls only when the queue is full, so the character
   // side and the byte side each stall on their own.
   b64d_pkg::group_type push_group;
   b64d_pkg::group_type pop_group;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;

   // The front end decodes each character as it transfers and, on the fourth
   // character of a group, pushes the 24-bit word with its byte count and the
   // end-of-message mark. Groups that give no bytes are dropped there.
   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_group (push_group)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .pop_group  (pop_group),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // The emitter sends the bytes of one group, most significant first, through a
   // registered output stage, and takes the next group as the last byte leaves.
   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_group (pop_group),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: tb/tb_base64_stream_decoder_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming base64 decoder core.
module tb_base64_stream_decoder_core;

   // Worst case is far below this: roughly 500 characters, each behind a random gap,
   // under 400 bytes, each behind a random sink stall, and the one long hold. The limit
   // leaves a wide margin on top of that.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_CHARS  = 445;
   localparam int QUIET_TAIL    = 60;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 20;

   // One character to send. A negative typed_count means the bytes come from the
   // decoder model below. Otherwise the row carries its own bytes, packed first byte
   // in the top bits.
   typedef struct {
      logic [7:0]  ch;
      logic        eom;
      int          typed_count;
      logic [23:0] typed_bytes;
   } char_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } decoded_byte_type;

   logic clock;
   logic reset;

   b64d_req_if req_ch ();
   b64d_rsp_if rsp_ch ();

   base64_stream_decoder_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   char_item_type    char_stream[$];
   decoded_byte_type pending_bytes[$];
   int               directed_count;
   int               mismatch_count;
   int               cycle_count;

   // Handshake between the sender and the sink process. Both are set at the
   // rising edge and read at the falling edge, so neither races.
   bit hold_request;
   bit quiet_phase;

   // Decoder model state: characters held in the open group, their six-bit values
   // packed oldest first, and the number of pad characters seen in the group.
   logic [1:0]  group_fill;
   logic [17:0] group_bits;
   logic [1:0]  group_pad_count;

   // The clock runs at 50 MHz.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The run is stopped if it hangs, e.g. when a byte that is owed never shows up.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Maps one character through the standard alphabet. Anything outside it, the pad
   // character included, stands for zero.
   function automatic logic [5:0] alphabet_value(input logic [7:0] ch);
      int code;
      code = int'(ch);
      if (code >= int'(b64d_pkg::CHAR_UPPER_A) && code <= int'(b64d_pkg::CHAR_UPPER_Z))
         return 6'(code - int'(b64d_pkg::CHAR_UPPER_A));
      if (code >= int'(b64d_pkg::CHAR_LOWER_A) && code <= int'(b64d_pkg::CHAR_LOWER_Z))
         return 6'(code - int'(b64d_pkg::CHAR_LOWER_A) + 26);
      if (code >= int'(b64d_pkg::CHAR_DIGIT_0) && code <= int'(b64d_pkg::CHAR_DIGIT_9))
         return 6'(code - int'(b64d_pkg::CHAR_DIGIT_0) + 52);
      if (ch == b64d_pkg::CHAR_PLUS)
         return 6'd62;
      if (ch == b64d_pkg::CHAR_SLASH)
         return 6'd63;
      return 6'd0;
   endfunction

   // The inverse: the character for a six-bit value.
   function automatic logic [7:0] alphabet_char(input int value);
      if (value < 26)
         return 8'(int'(b64d_pkg::CHAR_UPPER_A) + value);
      if (value < 52)
         return 8'(int'(b64d_pkg::CHAR_LOWER_A) + value - 26);
      if (value < 62)
         return 8'(int'(b64d_pkg::CHAR_DIGIT_0) + value - 52);
      if (value == 62)
         return b64d_pkg::CHAR_PLUS;
      return b64d_pkg::CHAR_SLASH;
   endfunction

   function automatic void clear_group();
      group_fill      = 2'd0;
      group_bits      = 18'd0;
      group_pad_count = 2'd0;
   endfunction

   // Advances the decoder model by one accepted character. When keep_bytes is set,
   // the bytes that the character releases are queued as expected output.
   function automatic void decode_char(input logic [7:0] ch, input logic eom,
                                       input bit keep_bytes);
      logic [23:0]      word;
      int               byte_total;
      decoded_byte_type entry;
      // Every pad character counts, wherever it stands in the group.
      if (ch == b64d_pkg::CHAR_PAD && group_pad_count != 2'd3)
         group_pad_count = group_pad_count + 2'd1;
      if (group_fill == 2'd3) begin
         word       = {group_bits, alphabet_value(ch)};
         // Each pad drops one byte from the tail; three or more leave nothing.
         byte_total = 3 - int'(group_pad_count);
         if (keep_bytes) begin
            for (int k = 0; k < byte_total; k++) begin
               entry.data_byte = word[23 - 8 * k -: 8];
               entry.last_byte = eom && (k == byte_total - 1);
               pending_bytes   = {pending_bytes, entry};
            end
         end
         clear_group();
      end else begin
         group_bits = {group_bits[11:0], alphabet_value(ch)};
         group_fill = group_fill + 2'd1;
         // A partial group at the end of a message is dropped silently.
         if (eom)
            clear_group();
      end
   endfunction

   // Appends a string of characters. The end-of-message flag, if any, goes on the
   // last one, and so do the typed bytes; the characters in front of it release none.
   function automatic void add_chars(input string text, input bit eom_on_last,
                                     input int typed_count, input logic [23:0] typed_bytes);
      char_item_type item;
      for (int i = 0; i < text.len(); i++) begin
         item.ch          = text[i];
         item.eom         = eom_on_last && (i == text.len() - 1);
         item.typed_count = (typed_count < 0) ? -1 :
                            ((i == text.len() - 1) ? typed_count : 0);
         item.typed_bytes = typed_bytes;
         char_stream      = {char_stream, item};
      end
   endfunction

   function automatic void add_char(input logic [7:0] ch, input logic eom);
      char_item_type item;
      item.ch          = ch;
      item.eom         = eom;
      item.typed_count = -1;
      item.typed_bytes = 24'd0;
      char_stream      = {char_stream, item};
   endfunction

   // Directed part. Rows with bytes typed in are the ones that can be read off by
   // hand; the rest go through the model.
   function automatic void build_directed_part();
      add_chars("AAAA", 1'b1, 3, 24'h000000);     // all-zero group right after reset
      add_chars("////", 1'b1, 3, 24'hFFFFFF);     // all-ones group
      add_chars("QQ==", 1'b1, 1, 24'h410000);     // two pads leave one byte
      add_chars("QUI=", 1'b1, 2, 24'h414200);     // one pad leaves two bytes
      add_chars("====", 1'b1, 0, 24'h000000);     // pads only, message with no bytes
      // Characters outside the alphabet mixed with pads in the middle of a group.
      add_chars("\377=@=", 1'b1, -1, 24'h000000);
      add_chars("+09z", 1'b0, -1, 24'h000000);    // group that does not end a message
      add_chars("+9z", 1'b1, -1, 24'h000000);     // partial group ended by the flag
      add_char(8'h00, 1'b1);                      // lone character, also a partial group
   endfunction

   // Random part. Most of it is well-formed messages of one to six groups with an
   // optional one or two pads at the tail. The rest is noise: runs of arbitrary codes,
   // heavy on pads, with the end flag set at random.
   function automatic void build_random_part();
      int group_total;
      int pad_total;
      int run_length;
      int stop_at;
      stop_at = char_stream.size() + RANDOM_CHARS;
      while (char_stream.size() < stop_at) begin
         if ($urandom_range(0, 4) != 0) begin
            group_total = $urandom_range(1, 6);
            pad_total   = $urandom_range(0, 2);
            for (int i = 0; i < 4 * group_total; i++) begin
               if (i >= 4 * group_total - pad_total)
                  add_char(b64d_pkg::CHAR_PAD, i == 4 * group_total - 1);
               else
                  add_char(alphabet_char($urandom_range(0, 63)), i == 4 * group_total - 1);
            end
         end else begin
            run_length = $urandom_range(1, 8);
            for (int i = 0; i < run_length; i++) begin
               if ($urandom_range(0, 2) == 0)
                  add_char(b64d_pkg::CHAR_PAD, $urandom_range(0, 3) == 0);
               else
                  add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
         end
      end
   endfunction

   // Sink side. Ready drops in random bursts, and once for a long hold that
   // lets the decoder's group queue fill up and push back on the character channel,
   // and no new burst starts during the quiet tail of the run.
   initial begin : byte_sink
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            stall_left   = $urandom_range(0, 14);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Every byte transfer is checked against the oldest byte still owed.
   always @(posedge clock) begin
      decoded_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bytes.size() == 0) begin
            mismatch_count++;
            $display("%0t: byte with nothing expected, expected none, actual data %h last %b",
                     $time, rsp_ch.data_byte, rsp_ch.last_byte);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_ch.data_byte !== want.data_byte) begin
               mismatch_count++;
               $display("%0t: data_byte mismatch, expected %h, actual %h",
                        $time, want.data_byte, rsp_ch.data_byte);
            end
            if (rsp_ch.last_byte !== want.last_byte) begin
               mismatch_count++;
               $display("%0t: last_byte mismatch, expected %b, actual %b",
                        $time, want.last_byte, rsp_ch.last_byte);
            end
         end
      end
   end

   // Character source and the overall sequence of the run.
   initial begin : char_source
      char_item_type    item;
      decoded_byte_type typed_entry;
      int               gap;
      mismatch_count        = 0;
      cycle_count           = 0;
      hold_request          = 1'b0;
      quiet_phase           = 1'b0;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.char_code      = 8'd0;
      req_ch.end_of_message = 1'b0;
      clear_group();

      build_directed_part();
      directed_count = char_stream.size();
      build_random_part();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int idx = 0; idx < char_stream.size(); idx++) begin
         item = char_stream[idx];
         // Random gaps before a transfer, except in the quiet tail.
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge clock);
         end
         req_ch.valid          <= 1'b1;
         req_ch.char_code      <= item.ch;
         req_ch.end_of_message <= item.eom;
         do
            @(posedge clock);
         while (!req_ch.ready);

         // The transfer took place at this edge; work out what it owes.
         if (item.typed_count < 0) begin
            decode_char(item.ch, item.eom, 1'b1);
         end else begin
            decode_char(item.ch, item.eom, 1'b0);
            for (int k = 0; k < item.typed_count; k++) begin
               typed_entry.data_byte = item.typed_bytes[23 - 8 * k -: 8];
               typed_entry.last_byte = item.eom && (k == item.typed_count - 1);
               pending_bytes         = {pending_bytes, typed_entry};
            end
         end
         // The long hold starts as the random part begins, so the sender keeps going.
         if (idx == directed_count - 1)
            hold_request = 1'b1;
         if (idx >= char_stream.size() - QUIET_TAIL - 1)
            quiet_phase = 1'b1;
         @(negedge clock);
      end
      req_ch.valid <= 1'b0;

      // Drain what is still owed, then keep watching for DRAIN_CYCLES so that any stray
      // byte shows. The cycle limit catches a byte that never arrives.
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
